// ----- rtl/core/ssb_pkg.sv -----
// Shared constants and types for the sphere screen bounds block.
package ssb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    // Configuration registers are 31-bit unsigned Q15.16 values.
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_PLANE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_SCALE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_SCALE_Y = 2'd2;

    localparam logic [CFG_W-1:0] NEAR_PLANE_RST   = 31'd6554;
    localparam logic [CFG_W-1:0] PROJ_SCALE_X_RST = 31'd65536;
    localparam logic [CFG_W-1:0] PROJ_SCALE_Y_RST = 31'd65536;

    // Flags that ride along with each divider stage.
    typedef struct packed {
        logic neg;
        logic zero;
        logic ovf;
    } t_div_flags;

endpackage

// ----- rtl/core/ssb_delay.sv -----
// Enabled shift line that keeps side data aligned with the arithmetic stages.
module ssb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

// ----- rtl/core/ssb_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module ssb_sqrt #(
    parameter int DATA_WIDTH = ssb_pkg::DATA_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*DATA_WIDTH-1:0] i_v,
    output logic [DATA_WIDTH-1:0]   o_root
);

    localparam int DW = DATA_WIDTH;
    localparam int WW = 2 * DW;
    localparam int RW = DW + 2;

    logic [RW-1:0] r_rem  [DW];
    logic [DW-1:0] r_root [DW];
    logic [WW-1:0] r_v    [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [RW-1:0] w_rem;
        logic [DW-1:0] w_root;
        logic [WW-1:0] w_v;
        logic [RW+1:0] w_rem2;
        logic [RW+1:0] w_trial;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_v    = i_v;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_v    = r_v[k-1];
        end

        assign w_rem2  = {w_rem, w_v[WW-1:WW-2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = (w_rem2 >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? RW'(w_rem2 - w_trial) : RW'(w_rem2);
                r_root[k] <= {w_root[DW-2:0], w_ge};
                r_v[k]    <= {w_v[WW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[DW-1];

endmodule

// ----- rtl/core/ssb_div.sv -----
// Pipelined signed fixed-point divider with saturation, one quotient bit per stage.
module ssb_div #(
    parameter int DATA_WIDTH = ssb_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = ssb_pkg::FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [2*DATA_WIDTH-1:0] i_num,
    input  logic signed [2*DATA_WIDTH-1:0] i_den,
    output logic signed [DATA_WIDTH:0]     o_quo
);

    localparam int DW = DATA_WIDTH;
    localparam int WW = 2 * DW;

    logic [WW-1:0]       r_ua;
    logic [WW-1:0]       r_ud;
    ssb_pkg::t_div_flags r_fa;

    logic [WW-1:0]       r_rem  [DW+1];
    logic [DW-1:0]       r_q    [DW+1];
    logic [DW-1:0]       r_feed [DW+1];
    logic [WW-1:0]       r_uds  [DW+1];
    ssb_pkg::t_div_flags r_fl   [DW+1];

    logic signed [DW:0]  r_quo;

    // Magnitudes and sign of the quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua      <= i_num[WW-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_ud      <= i_den[WW-1] ? $unsigned(-i_den) : $unsigned(i_den);
            r_fa.neg  <= i_num[WW-1] ^ i_den[WW-1];
            r_fa.zero <= (i_num == '0);
            r_fa.ovf  <= 1'b0;
        end
    end

    // The scaled dividend is ua * 2^FRAC_BITS; it overflows when it reaches
    // ud * 2^DATA_WIDTH, and otherwise its top part is already below ud.
    logic [WW+FRAC_BITS-1:0] w_nb;
    logic                    w_ovf;

    assign w_nb  = {r_ua, {FRAC_BITS{1'b0}}};
    assign w_ovf = ({{(DW-FRAC_BITS){1'b0}}, w_nb} >= {r_ud, {DW{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= {{(DW-FRAC_BITS){1'b0}}, w_nb[WW+FRAC_BITS-1:DW]};
            r_feed[0]    <= w_nb[DW-1:0];
            r_q[0]       <= '0;
            r_uds[0]     <= r_ud;
            r_fl[0].neg  <= r_fa.neg;
            r_fl[0].zero <= r_fa.zero;
            r_fl[0].ovf  <= w_ovf;
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_step
        logic [WW:0] w_rem2;
        logic        w_ge;

        assign w_rem2 = {r_rem[k-1], r_feed[k-1][DW-1]};
        assign w_ge   = (w_rem2 >= {1'b0, r_uds[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? WW'(w_rem2 - {1'b0, r_uds[k-1]}) : WW'(w_rem2);
                r_q[k]    <= {r_q[k-1][DW-2:0], w_ge};
                r_feed[k] <= {r_feed[k-1][DW-2:0], 1'b0};
                r_uds[k]  <= r_uds[k-1];
                r_fl[k]   <= r_fl[k-1];
            end
        end
    end

    logic [DW-1:0] w_mag;

    assign w_mag = r_fl[DW].ovf ? {DW{1'b1}} : r_q[DW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_fl[DW].zero) begin
                r_quo <= '0;
            end else if (r_fl[DW].neg) begin
                r_quo <= -$signed({1'b0, w_mag});
            end else begin
                r_quo <= $signed({1'b0, w_mag});
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// ----- rtl/core/sphere_screen_bounds.sv -----
// Top level of the sphere screen bounds block: near test, tangent bounds and uv mapping.
//
// This block takes one view-space sphere per transaction (center x, y, z
// as signed Q16.16 and radius as unsigned Q15.16, with FRAC_BITS fraction
// bits) and returns the uv rectangle that its perspective image covers. A
// sphere that reaches in front of the near plane is reported with visible
// low and all four bounds zero. The block is a single pipeline that accepts
// a new sphere in every clock cycle while o_stall is low. The square root
// resolves one root bit per stage, and the four parallel dividers resolve
// one quotient bit per stage plus three stages for sign handling, overflow
// detection and saturation. The last stage is the output register.
// The whole pipeline advances in lockstep and holds while a finished result
// waits on a stalled output, so o_stall is high only in that case. The three
// configuration registers (near plane, projection scale x and y) accept a
// write in every cycle and must only be changed while no sphere is in flight.
module sphere_screen_bounds #(
    parameter int FRAC_BITS  = ssb_pkg::FRAC_BITS,
    parameter int DATA_WIDTH = ssb_pkg::DATA_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [DATA_WIDTH-1:0]      i_center_x,
    input  logic signed [DATA_WIDTH-1:0]      i_center_y,
    input  logic signed [DATA_WIDTH-1:0]      i_center_z,
    input  logic        [DATA_WIDTH-2:0]      i_sphere_radius,

    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_visible,
    output logic signed [DATA_WIDTH-1:0]      o_u_min,
    output logic signed [DATA_WIDTH-1:0]      o_v_min,
    output logic signed [DATA_WIDTH-1:0]      o_u_max,
    output logic signed [DATA_WIDTH-1:0]      o_v_max,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ssb_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DW  = DATA_WIDTH;
    localparam int WW  = 2 * DW;
    localparam int CW  = ssb_pkg::CFG_W;
    localparam int LAT = 2 * DW + 10;
    // Width of the near-plane compare: room for the radius plus near sum.
    localparam int NW  = ((DW > CW) ? DW : CW) + 2;
    // Width of a quotient times a scale factor.
    localparam int PW  = DW + CW + 2;

    localparam logic signed [PW:0] S_MAX = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW:0] S_MIN = {{(PW-DW+2){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [PW:0] HALF  =
        {{(PW+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index past the
    // last register is simply dropped.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_near;
    logic [CW-1:0] r_scale_x;
    logic [CW-1:0] r_scale_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near    <= ssb_pkg::NEAR_PLANE_RST;
            r_scale_x <= ssb_pkg::PROJ_SCALE_X_RST;
            r_scale_y <= ssb_pkg::PROJ_SCALE_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssb_pkg::CFG_NEAR_PLANE:   r_near    <= i_cfg_data;
                ssb_pkg::CFG_PROJ_SCALE_X: r_scale_x <= i_cfg_data;
                ssb_pkg::CFG_PROJ_SCALE_Y: r_scale_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Every stage moves together; the only thing that
    // can hold the pipeline is a result in the output register that the
    // downstream side is not taking.
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 0: input register.
    logic signed [DW-1:0] r_x0, r_y0, r_z0;
    logic        [DW-2:0] r_r0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= i_center_x;
            r_y0 <= i_center_y;
            r_z0 <= i_center_z;
            r_r0 <= i_sphere_radius;
        end
    end

    // Stage 1: squares and the near-plane test.
    logic signed [NW-1:0] w_near_sum;
    logic signed [NW-1:0] w_z_ext;

    assign w_near_sum = $signed(NW'(r_r0) + NW'(r_near));
    assign w_z_ext    = NW'(r_z0);

    // Full-width signed squares of the center coordinates.
    logic signed [WW-1:0] w_x2, w_y2, w_z2;

    assign w_x2 = r_x0 * r_x0;
    assign w_y2 = r_y0 * r_y0;
    assign w_z2 = r_z0 * r_z0;

    logic signed [DW-1:0] r_x1, r_y1, r_z1;
    logic        [DW-2:0] r_r1;
    logic        [WW-1:0] r_x2, r_y2, r_z2, r_r2;
    logic                 r_vis1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= r_x0;
            r_y1   <= r_y0;
            r_z1   <= r_z0;
            r_r1   <= r_r0;
            r_x2   <= w_x2;
            r_y2   <= w_y2;
            r_z2   <= w_z2;
            r_r2   <= WW'(r_r0) * WW'(r_r0);
            r_vis1 <= !(w_z_ext < w_near_sum);
        end
    end

    // Stage 2: radicands c*c + z*z - r*r for both axes.
    logic [WW-1:0] r_sqx, r_sqy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx <= r_x2 + r_z2 - r_r2;
            r_sqy <= r_y2 + r_z2 - r_r2;
        end
    end

    // Square roots, with the sphere itself carried alongside.
    logic [DW-1:0] w_vx, w_vy;

    ssb_sqrt #(.DATA_WIDTH(DW)) u_sqrt_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r_sqx),
        .o_root (w_vx)
    );

    ssb_sqrt #(.DATA_WIDTH(DW)) u_sqrt_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r_sqy),
        .o_root (w_vy)
    );

    logic [4*DW-2:0] w_side;

    ssb_delay #(.WIDTH(4*DW-1), .DEPTH(DW+1)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r_x1, r_y1, r_z1, r_r1}),
        .o_q   (w_side)
    );

    logic signed [DW-1:0] w_xs, w_ys, w_zs, w_rs;

    assign w_xs = w_side[4*DW-2:3*DW-1];
    assign w_ys = w_side[3*DW-2:2*DW-1];
    assign w_zs = w_side[2*DW-2:DW-1];
    assign w_rs = {1'b0, w_side[DW-2:0]};

    // Visibility goes straight to the scale stage, next to the quotients.
    logic w_vis;

    ssb_delay #(.WIDTH(1), .DEPTH(2*DW+6)) u_vis_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_vis1),
        .o_q   (w_vis)
    );

    // Product stage: each product is halved with floor, which is the
    // product with its lowest bit dropped.
    logic signed [DW:0] w_vxs, w_vys;

    assign w_vxs = {1'b0, w_vx};
    assign w_vys = {1'b0, w_vy};

    logic signed [WW:0] w_m_vcx, w_m_vzx, w_m_vcy, w_m_vzy, w_m_rcx, w_m_rcy, w_m_rz;

    assign w_m_vcx = w_vxs * w_xs;
    assign w_m_vzx = w_vxs * w_zs;
    assign w_m_vcy = w_vys * w_ys;
    assign w_m_vzy = w_vys * w_zs;
    assign w_m_rcx = w_rs * w_xs;
    assign w_m_rcy = w_rs * w_ys;
    assign w_m_rz  = w_rs * w_zs;

    logic signed [WW-1:0] r_vcx, r_vzx, r_vcy, r_vzy, r_rcx, r_rcy, r_rz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vcx <= w_m_vcx[WW:1];
            r_vzx <= w_m_vzx[WW:1];
            r_vcy <= w_m_vcy[WW:1];
            r_vzy <= w_m_vzy[WW:1];
            r_rcx <= w_m_rcx[WW:1];
            r_rcy <= w_m_rcy[WW:1];
            r_rz  <= w_m_rz[WW:1];
        end
    end

    // Numerator and denominator stage for the low and high tangent bounds.
    logic signed [WW-1:0] r_nxlo, r_dxlo, r_nxhi, r_dxhi;
    logic signed [WW-1:0] r_nylo, r_dylo, r_nyhi, r_dyhi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nxlo <= r_vcx - r_rz;
            r_dxlo <= r_vzx + r_rcx;
            r_nxhi <= r_vcx + r_rz;
            r_dxhi <= r_vzx - r_rcx;
            r_nylo <= r_vcy - r_rz;
            r_dylo <= r_vzy + r_rcy;
            r_nyhi <= r_vcy + r_rz;
            r_dyhi <= r_vzy - r_rcy;
        end
    end

    // Four dividers in parallel.
    logic signed [DW:0] w_qxlo, w_qxhi, w_qylo, w_qyhi;

    ssb_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_xlo (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_nxlo), .i_den (r_dxlo), .o_quo (w_qxlo)
    );

    ssb_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_xhi (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_nxhi), .i_den (r_dxhi), .o_quo (w_qxhi)
    );

    ssb_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_ylo (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_nylo), .i_den (r_dylo), .o_quo (w_qylo)
    );

    ssb_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div_yhi (
        .i_clk (i_clk), .i_en (w_en), .i_num (r_nyhi), .i_den (r_dyhi), .o_quo (w_qyhi)
    );

    // Scale stage: quotient times the projection element.
    logic signed [CW:0] w_scx, w_scy;

    assign w_scx = {1'b0, r_scale_x};
    assign w_scy = {1'b0, r_scale_y};

    logic signed [PW-1:0] r_pxlo, r_pxhi, r_pylo, r_pyhi;
    logic                 r_vism;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pxlo <= w_qxlo * w_scx;
            r_pxhi <= w_qxhi * w_scx;
            r_pylo <= w_qylo * w_scy;
            r_pyhi <= w_qyhi * w_scy;
            r_vism <= w_vis;
        end
    end

    // Output stage: halve with floor, offset by one half and saturate.
    // The y axis is mirrored, so v comes from one half minus the offset.
    function automatic logic signed [DW-1:0] f_sat(input logic signed [PW:0] s);
        if (s > S_MAX) begin
            f_sat = S_MAX[DW-1:0];
        end else if (s < S_MIN) begin
            f_sat = S_MIN[DW-1:0];
        end else begin
            f_sat = s[DW-1:0];
        end
    endfunction

    logic signed [PW:0] w_exlo, w_exhi, w_eylo, w_eyhi;
    logic signed [PW:0] w_hxlo, w_hxhi, w_hylo, w_hyhi;

    assign w_exlo = {r_pxlo[PW-1], r_pxlo};
    assign w_exhi = {r_pxhi[PW-1], r_pxhi};
    assign w_eylo = {r_pylo[PW-1], r_pylo};
    assign w_eyhi = {r_pyhi[PW-1], r_pyhi};

    assign w_hxlo = w_exlo >>> (FRAC_BITS + 1);
    assign w_hxhi = w_exhi >>> (FRAC_BITS + 1);
    assign w_hylo = w_eylo >>> (FRAC_BITS + 1);
    assign w_hyhi = w_eyhi >>> (FRAC_BITS + 1);

    logic                 r_vis;
    logic signed [DW-1:0] r_u_min, r_v_min, r_u_max, r_v_max;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vis <= r_vism;
            if (r_vism) begin
                r_u_min <= f_sat(HALF + w_hxlo);
                r_v_min <= f_sat(HALF - w_hyhi);
                r_u_max <= f_sat(HALF + w_hxhi);
                r_v_max <= f_sat(HALF - w_hylo);
            end else begin
                r_u_min <= '0;
                r_v_min <= '0;
                r_u_max <= '0;
                r_v_max <= '0;
            end
        end
    end

    assign o_visible = r_vis;
    assign o_u_min   = r_u_min;
    assign o_v_min   = r_v_min;
    assign o_u_max   = r_u_max;
    assign o_v_max   = r_v_max;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A rejected sphere always leaves with an all-zero rectangle.
    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |->
            o_u_min == '0 && o_v_min == '0 && o_u_max == '0 && o_v_max == '0)
        else $error("rejected sphere has nonzero bounds");

    // An accepted transaction enters the valid chain on the next edge.
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted sphere did not enter the pipeline");

    // A held pipeline does not move its valid bits.
    a_hold_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline advanced while held");

    // A near-plane write lands in its register.
    a_cfg_near : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index == ssb_pkg::CFG_NEAR_PLANE
            |=> r_near == $past(i_cfg_data))
        else $error("near plane write lost");

endmodule
